// ----- sv/ring_buffer_fifo_core_defines.svh -----
// ----------------------------------------------------------------------------
// ring_buffer_fifo_core_defines
// assertion macros used by rbf_ctrl in the ring buffer fifo rtl
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_FIFO_CORE_DEFINES_SVH
`define RING_BUFFER_FIFO_CORE_DEFINES_SVH

// property checked at every clock edge outside reset
`define RBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rbf_pkg
// constants and types shared by the ring buffer fifo modules
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int PTR_W     = $clog2(MAX_DEPTH);
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_OVERWRITE = 2'd1,
    KIND_READ      = 2'd2,
    KIND_FLUSH     = 2'd3
  } kind_t;

  // one access to the slot store per transfer
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr_a;
    logic [PTR_W-1:0]  raddr_b;
  } mem_req_t;

  // status of one operation, carried alongside the store read
  typedef struct packed {
    logic             ok;
    logic             pop;
    logic [CNT_W-1:0] fill;
    logic             full;
    logic [CNT_W-1:0] free;
  } op_info_t;

endpackage

// ----- sv/rbf_store.sv -----
// ----------------------------------------------------------------------------
// rbf_store
// slot memory with one write port and two registered read ports
// ----------------------------------------------------------------------------
module rbf_store (
  input  logic                             clk,
  input  logic                             rst,
  input  rbf_pkg::mem_req_t                req,
  output logic [rbf_pkg::WORD_W-1:0]       rd_a,
  output logic [rbf_pkg::WORD_W-1:0]       rd_b
);

  logic [rbf_pkg::WORD_W-1:0] mem [rbf_pkg::MAX_DEPTH];
  logic [rbf_pkg::MAX_DEPTH-1:0] written;

  logic [rbf_pkg::WORD_W-1:0] rdat_a;
  logic [rbf_pkg::WORD_W-1:0] rdat_b;
  logic [rbf_pkg::WORD_W-1:0] wdata_q;
  logic                       vld_a;
  logic                       vld_b;
  logic                       fwd_a;
  logic                       fwd_b;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdat_a <= mem[req.raddr_a];
      rdat_b <= mem[req.raddr_b];
    end
  end

  // slots never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  // forward the word written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (req.re) begin
      vld_a   <= written[req.raddr_a];
      vld_b   <= written[req.raddr_b];
      fwd_a   <= req.we && (req.waddr == req.raddr_a);
      fwd_b   <= req.we && (req.waddr == req.raddr_b);
      wdata_q <= req.wdata;
    end
  end

  always_comb begin
    rd_a = fwd_a ? wdata_q : (vld_a ? rdat_a : '0);
    rd_b = fwd_b ? wdata_q : (vld_b ? rdat_b : '0);
  end

endmodule

// ----- sv/rbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbf_ctrl
// head and tail pointers, fill count and capacity register
// ----------------------------------------------------------------------------
`include "ring_buffer_fifo_core_defines.svh"

module rbf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rbf_pkg::CNT_W-1:0]   cfg_cap,
  input  logic                        acc,
  input  rbf_pkg::kind_t              kind,
  input  logic [rbf_pkg::WORD_W-1:0]  data_in,
  output rbf_pkg::mem_req_t           req,
  output rbf_pkg::op_info_t           info
);

  logic [rbf_pkg::CNT_W-1:0] capacity;
  logic [rbf_pkg::PTR_W-1:0] head;
  logic [rbf_pkg::PTR_W-1:0] tail;
  logic [rbf_pkg::CNT_W-1:0] count;

  logic [rbf_pkg::PTR_W-1:0] head_next;
  logic [rbf_pkg::PTR_W-1:0] tail_next;
  logic [rbf_pkg::CNT_W-1:0] count_next;
  logic [rbf_pkg::CNT_W-1:0] eff_cap;
  logic [rbf_pkg::PTR_W-1:0] head_adv;
  logic [rbf_pkg::PTR_W-1:0] tail_adv;
  logic                      full;
  logic                      store_op;
  logic                      pop_op;
  logic                      ok_op;

  // pointers wrap at the capacity in use, not at the memory depth
  function automatic logic [rbf_pkg::PTR_W-1:0] advance(
    input logic [rbf_pkg::PTR_W-1:0] p,
    input logic [rbf_pkg::CNT_W-1:0] cap
  );
    logic [rbf_pkg::CNT_W-1:0] n;
    n = rbf_pkg::CNT_W'(p) + rbf_pkg::CNT_W'(1);
    return (n >= cap) ? '0 : n[rbf_pkg::PTR_W-1:0];
  endfunction

  always_comb begin
    if (capacity == '0) begin
      eff_cap = rbf_pkg::CNT_W'(1);
    end else if (capacity > rbf_pkg::CNT_W'(rbf_pkg::MAX_DEPTH)) begin
      eff_cap = rbf_pkg::CNT_W'(rbf_pkg::MAX_DEPTH);
    end else begin
      eff_cap = capacity;
    end
    full     = count >= eff_cap;
    head_adv = advance(head, eff_cap);
    tail_adv = advance(tail, eff_cap);
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    store_op   = 1'b0;
    pop_op     = 1'b0;
    ok_op      = 1'b1;
    case (kind)
      rbf_pkg::KIND_WRITE: begin
        if (full) begin
          ok_op = 1'b0;
        end else begin
          store_op   = 1'b1;
          tail_next  = tail_adv;
          count_next = count + rbf_pkg::CNT_W'(1);
        end
      end
      rbf_pkg::KIND_OVERWRITE: begin
        store_op  = 1'b1;
        tail_next = tail_adv;
        if (full) begin
          head_next = head_adv;
        end else begin
          count_next = count + rbf_pkg::CNT_W'(1);
        end
      end
      rbf_pkg::KIND_READ: begin
        if (count == '0) begin
          ok_op = 1'b0;
        end else begin
          pop_op     = 1'b1;
          head_next  = head_adv;
          count_next = count - rbf_pkg::CNT_W'(1);
        end
      end
      rbf_pkg::KIND_FLUSH: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end
      default: begin
        ok_op = 1'b0;
      end
    endcase
  end

  always_comb begin
    req.we      = acc && store_op;
    req.waddr   = tail;
    req.wdata   = data_in;
    req.re      = acc;
    req.raddr_a = head;
    req.raddr_b = head_next;
    info.ok     = ok_op;
    info.pop    = pop_op;
    info.fill   = count_next;
    info.full   = count_next >= eff_cap;
    info.free   = eff_cap - count_next;
  end

  // a capacity write also empties the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rbf_pkg::CAP_RESET;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_cap;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (acc) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  `RBF_ASSERT(a_count_le_cap, count <= eff_cap, "fill count above capacity")
  `RBF_ASSERT(a_head_in_range, rbf_pkg::CNT_W'(head) < eff_cap, "head beyond capacity")
  `RBF_ASSERT(a_tail_in_range, rbf_pkg::CNT_W'(tail) < eff_cap, "tail beyond capacity")
  `RBF_ASSERT(a_ends_meet, (count == '0 || full) |-> head == tail, "pointers disagree")
  `RBF_ASSERT_NEXT(a_cfg_clears, cfg_we, {head, tail, count} == '0, "cfg write left state")

endmodule

// ----- sv/ring_buffer_fifo_core.sv -----
// a result is registered with the store read and status, then in the output register
// throughput: one operation per cycle while the output is not stalled, set by the
// single write port of the slot memory and the pointer registers updated at each transfer
// reset: pointers and count clear, capacity returns to 10, per-slot written
// flags clear so untouched slots read as zero
// ----------------------------------------------------------------------------
// ring_buffer_fifo_core
// circular fifo with overwrite, flush and programmable capacity
// ----------------------------------------------------------------------------
module ring_buffer_fifo_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbf_pkg::CNT_W-1:0]         capacity,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic signed [rbf_pkg::WORD_W-1:0] data_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              ok,
  output logic signed [rbf_pkg::WORD_W-1:0] read_data,
  output logic signed [rbf_pkg::WORD_W-1:0] head_data,
  output logic [rbf_pkg::CNT_W-1:0]         fill_count,
  output logic                              is_empty,
  output logic                              is_full,
  output logic [rbf_pkg::CNT_W-1:0]         free_slots
);

  rbf_pkg::mem_req_t          req;
  rbf_pkg::op_info_t          info;
  rbf_pkg::op_info_t          s1_info;
  logic                       s1_valid;
  logic                       s1_adv;
  logic                       acc;
  logic [rbf_pkg::WORD_W-1:0] rd_a;
  logic [rbf_pkg::WORD_W-1:0] rd_b;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign acc       = in_valid && in_ready;

  rbf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_cap (capacity),
    .acc     (acc),
    .kind    (rbf_pkg::kind_t'(kind)),
    .data_in (data_in),
    .req     (req),
    .info    (info)
  );

  rbf_store u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // status waits here for the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_info <= info;
    end
  end

  // output register parts the result from the next transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ok         <= s1_info.ok;
      read_data  <= s1_info.pop ? rd_a : '0;
      head_data  <= rd_b;
      fill_count <= s1_info.fill;
      is_empty   <= (s1_info.fill == '0);
      is_full    <= s1_info.full;
      free_slots <= s1_info.free;
    end
  end

endmodule
